/* design/ssn_pkg.sv */
package ssn_pkg;

	localparam int MAX_RANK  = 8;
	localparam int IDX_W     = 32;
	localparam int WIDE_W    = IDX_W + 2;
	localparam int DIV_STEPS = IDX_W;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_ZERO_STEP = 2'd1,
		ERR_DIRECTION = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [2:0]        axis_number;
		logic signed [31:0] slice_start;
		logic signed [31:0] slice_end;
		logic signed [31:0] slice_stride;
		logic [30:0]       dim_size;
		logic              flag_inferred;
		logic              last_axis_in;
	} in_req_t;

	typedef struct packed {
		logic [2:0]        axis_out;
		logic [30:0]       out_length;
		logic signed [31:0] norm_start;
		logic signed [31:0] norm_end;
		logic signed [31:0] norm_stride;
		logic [1:0]        error_code;
		logic              last_axis_out;
	} out_res_t;

	// Fields that ride alongside the divider
	typedef struct packed {
		logic [2:0]         axis;
		logic [IDX_W-1:0]   ns;
		logic [IDX_W-1:0]   ne;
		logic [IDX_W-1:0]   stride;
		err_code_t          err;
		logic               last;
		logic               reduce;
	} side_t;

	typedef struct packed {
		logic               valid;
		logic [2*IDX_W-1:0] acc;
		logic [IDX_W-1:0]   dvsr;
		side_t              side;
	} div_lane_t;

endpackage

/* design/ssn_front.sv */
module ssn_front
	import ssn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  in_req_t             req,
	input  logic [MAX_RANK-1:0] mask,
	output div_lane_t           lane
);

	// stage 1: capture request and reduce decision
	logic    valid_s1;
	in_req_t req_s1;
	logic    reduce_s1;

	logic reduce_c;
	assign reduce_c = (req.slice_start == -32'sd1) && (req.slice_end == 32'sd0)
		&& req.flag_inferred && mask[req.axis_number];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1    <= req;
			reduce_s1 <= reduce_c;
		end
	end

	// stage 2: normalize start and end, classify errors
	logic signed [WIDE_W-1:0] st, en_i, sd, d;
	logic                     neg;
	logic signed [WIDE_W-1:0] ls_a, le_a, ls_c, le_c, ns_c, ne_c, mx_st, mn_st, mx_en, mn_en;
	err_code_t                err_c;

	always_comb begin
		st   = WIDE_W'(req_s1.slice_start);
		en_i = WIDE_W'(req_s1.slice_end);
		sd   = WIDE_W'(req_s1.slice_stride);
		d    = WIDE_W'({1'b0, req_s1.dim_size});
		neg  = req_s1.slice_stride[31];

		ls_a = st + d;
		le_a = en_i + d;
		ls_c = (st < 0) ? ((ls_a < 0) ? '0 : ls_a) : st;
		le_c = ((en_i < 0) && !((en_i == -1) && neg)) ? ((le_a < 0) ? '0 : le_a) : en_i;
		if (neg) begin
			ls_c = ls_c + 1;
			le_c = le_c + 1;
		end

		if (reduce_s1) begin
			err_c = ERR_NONE;
		end else if (sd == 0) begin
			err_c = ERR_ZERO_STEP;
		end else if (neg ? (ls_c < le_c) : (ls_c > le_c)) begin
			err_c = ERR_DIRECTION;
		end else begin
			err_c = ERR_NONE;
		end

		mx_st = (st > -d) ? st : -d;
		mn_st = (st < d - 1) ? st : d - 1;
		mx_en = (en_i > -d - 1) ? en_i : -d - 1;
		mn_en = (en_i < d) ? en_i : d;
		if (neg) begin
			ns_c = (st < 0) ? mx_st : mn_st - d;
			ne_c = (en_i < 0) ? mx_en : en_i - d;
		end else begin
			ns_c = (st < 0) ? mx_st + d : mn_st;
			ne_c = (en_i < 0) ? le_a : mn_en;
		end
	end

	logic                     valid_s2;
	logic signed [WIDE_W-1:0] ls_s2, le_s2, d_s2;
	logic [IDX_W-1:0]         ns_s2, ne_s2, step_s2, sd_s2;
	logic                     neg_s2, reduce_s2, last_s2;
	logic [2:0]               axis_s2;
	err_code_t                err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ls_s2     <= ls_c;
			le_s2     <= le_c;
			d_s2      <= d;
			ns_s2     <= ns_c[IDX_W-1:0];
			ne_s2     <= ne_c[IDX_W-1:0];
			sd_s2     <= req_s1.slice_stride;
			step_s2   <= neg ? (IDX_W'(0) - req_s1.slice_stride) : req_s1.slice_stride;
			neg_s2    <= neg;
			reduce_s2 <= reduce_s1;
			last_s2   <= req_s1.last_axis_in;
			axis_s2   <= req_s1.axis_number;
			err_s2    <= err_c;
		end
	end

	// stage 3: clamped span, ceiling dividend, reduced end
	logic signed [WIDE_W-1:0] lo, hi, left, right;
	logic [IDX_W-1:0]         span, ne_f;

	always_comb begin
		lo    = (ls_s2 < le_s2) ? ls_s2 : le_s2;
		hi    = (ls_s2 > le_s2) ? ls_s2 : le_s2;
		left  = (lo > 0) ? lo : '0;
		right = (hi < d_s2) ? hi : d_s2;
		span  = (right > left) ? IDX_W'(right - left) : '0;
		ne_f  = reduce_s2 ? (neg_s2 ? ns_s2 - 1'b1 : ns_s2 + 1'b1) : ne_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane <= '0;
		end else if (en) begin
			lane.valid       <= valid_s2;
			lane.acc         <= {{IDX_W{1'b0}}, span + step_s2 - 1'b1};
			lane.dvsr        <= step_s2;
			lane.side.axis   <= axis_s2;
			lane.side.ns     <= (err_s2 != ERR_NONE) ? '0 : ns_s2;
			lane.side.ne     <= (err_s2 != ERR_NONE) ? '0 : ne_f;
			lane.side.stride <= sd_s2;
			lane.side.err    <= err_s2;
			lane.side.last   <= last_s2;
			lane.side.reduce <= reduce_s2;
		end
	end

endmodule

/* design/ssn_cell.sv */
module ssn_cell
	import ssn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_lane_t din,
	output div_lane_t dout
);

	// one restoring division step: shift, trial subtract, set quotient bit
	logic [2*IDX_W-1:0] sh;
	logic [IDX_W-1:0]   rem;
	logic [2*IDX_W-1:0] acc_n;

	always_comb begin
		sh  = {din.acc[2*IDX_W-2:0], 1'b0};
		rem = sh[2*IDX_W-1:IDX_W];
		if (rem >= din.dvsr) begin
			acc_n = {rem - din.dvsr, sh[IDX_W-1:1], 1'b1};
		end else begin
			acc_n = sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout.valid <= din.valid;
			dout.acc   <= acc_n;
			dout.dvsr  <= din.dvsr;
			dout.side  <= din.side;
		end
	end

endmodule

/* design/strided_slice_param_normalizer.sv */
// Channel | Signals                         | Direction
// request | in_valid, in_stall, in_req      | in
// result  | out_valid, out_stall, out_res   | out
// config  | cfg_we, cfg_wdata               | in
//
// One request per cycle while in_stall is low. Each request passes through
// three front stages (capture, normalize, span), 32 division cells (one
// quotient bit each) and the output register.
// arst_n clears all valid bits, the skid register and the decrease mask.
// A result arriving while the output is stalled parks in a one-entry skid
// register; while it is full the chain freezes and the request side stalls.
module strided_slice_param_normalizer
	import ssn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_req_t    in_req,
	output logic       out_valid,
	input  logic       out_stall,
	output out_res_t   out_res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [MAX_RANK-1:0] mask_q;
	logic                adv;
	logic                skid_valid_q;
	out_res_t            skid_res_q;

	// hold mask until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// advance the chain while the skid register is empty
	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;

	div_lane_t lane [0:DIV_STEPS];

	ssn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (in_valid),
		.req      (in_req),
		.mask     (mask_q),
		.lane     (lane[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		ssn_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (lane[i]),
			.dout   (lane[i+1])
		);
	end

	// build the result
	side_t       fs;
	logic [30:0] len_c;
	out_res_t    res_c;

	always_comb begin
		fs = lane[DIV_STEPS].side;
		if (fs.reduce) begin
			len_c = 31'd1;
		end else if (fs.err != ERR_NONE) begin
			len_c = '0;
		end else begin
			len_c = lane[DIV_STEPS].acc[30:0];
		end
		res_c.axis_out      = fs.axis;
		res_c.out_length    = len_c;
		res_c.norm_start    = fs.ns;
		res_c.norm_end      = fs.ne;
		res_c.norm_stride   = fs.stride;
		res_c.error_code    = fs.err;
		res_c.last_axis_out = fs.last;
	end

	// hold a stalled result, park the next one in the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			out_res      <= '0;
			skid_valid_q <= 1'b0;
			skid_res_q   <= '0;
		end else if (adv) begin
			if (out_valid && out_stall) begin
				skid_valid_q <= lane[DIV_STEPS].valid;
				skid_res_q   <= res_c;
			end else begin
				out_valid <= lane[DIV_STEPS].valid;
				out_res   <= res_c;
			end
		end else if (!out_stall) begin
			out_valid    <= 1'b1;
			out_res      <= skid_res_q;
			skid_valid_q <= 1'b0;
		end
	end

endmodule
